// ===== rtl/core/assert_macros.svh =====
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the next cycle, ignored while in reset
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle, checked during reset too
`define ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/npcc_pkg.sv =====
// shared types, constants and palette rom of the nearest palette color cache
package npcc_pkg;

  localparam int DEF_CACHE_DEPTH  = 4096;
  localparam int DEF_PALETTE_SIZE = 16;

  localparam int COMP_W  = 8;
  localparam int COLOR_W = 24;
  localparam int CNT_W   = 5;
  localparam int IDX_W   = 4;
  localparam int DIST_W  = 24;
  localparam int ENTRY_W = 1 + COLOR_W + CNT_W + IDX_W;

  localparam logic [DIST_W-1:0] DIST_START = 24'hffffff;

  typedef logic [1:0] result_src_t;
  localparam result_src_t SRC_DUMP   = 2'd0;
  localparam result_src_t SRC_HIT    = 2'd1;
  localparam result_src_t SRC_SEARCH = 2'd2;

  typedef struct packed {
    logic        clear_step;
    logic        load;
    logic        lookup;
    logic        search_start;
    logic        search_step;
    logic        cache_write;
    logic        result_load;
    result_src_t src;
  } cmd_t;

  typedef struct packed {
    logic clear_done;
    logic dump_mode;
    logic tag_hit;
    logic search_done;
  } status_t;

  // text-mode palette as {red, green, blue}
  function automatic logic [COLOR_W-1:0] pal_color(input logic [IDX_W-1:0] idx);
    logic [COLOR_W-1:0] c;
    unique case (idx)
      4'd0:  c = 24'h000000;
      4'd1:  c = 24'h800000;
      4'd2:  c = 24'h008000;
      4'd3:  c = 24'haa5500;
      4'd4:  c = 24'h000080;
      4'd5:  c = 24'h800080;
      4'd6:  c = 24'h008080;
      4'd7:  c = 24'haaaaaa;
      4'd8:  c = 24'h555555;
      4'd9:  c = 24'hff5555;
      4'd10: c = 24'h55ff55;
      4'd11: c = 24'hffff55;
      4'd12: c = 24'h5555ff;
      4'd13: c = 24'hff55ff;
      4'd14: c = 24'h55ffff;
      4'd15: c = 24'hffffff;
    endcase
    return c;
  endfunction

endpackage

// ===== rtl/core/nearest_palette_color_cache_unit.sv =====
// top level of the nearest palette color cache
//
//  channel  | handshake            | payload
//  ---------+----------------------+---------------------------------------
//  input    | in_valid / in_ready  | red, green, blue, palette_count
//  output   | out_valid / out_ready| color_index, cache_hit
//  config   | cfg_write_en         | cfg_write_data (dump mode)
//
// one item is in flight at a time; the search loop over palette entries sets the miss time
// a hit passes through lookup, check and finish; a miss searches the palette entries between
// check and finish; dump mode goes from the accept straight to finish
// after reset a clearing pass writes every cache line invalid (CACHE_DEPTH lines, 4096
// by default) with in_ready low; config writes are taken during it
// the result sits in an output register, so a stalled out_ready does not block the
// next accept; only the following result waits for the register to drain
module nearest_palette_color_cache_unit #(
  parameter int CACHE_DEPTH  = npcc_pkg::DEF_CACHE_DEPTH,
  parameter int PALETTE_SIZE = npcc_pkg::DEF_PALETTE_SIZE
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_write_en,
  input  logic                         cfg_write_data,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [npcc_pkg::COMP_W-1:0]  red,
  input  logic [npcc_pkg::COMP_W-1:0]  green,
  input  logic [npcc_pkg::COMP_W-1:0]  blue,
  input  logic [npcc_pkg::CNT_W-1:0]   palette_count,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [npcc_pkg::IDX_W-1:0]   color_index,
  output logic                         cache_hit
);

  // commands from the state machine, status back from the datapath
  npcc_pkg::cmd_t    cmd;
  npcc_pkg::status_t status;

  npcc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  // cache memory, slot hash, one palette entry compared per cycle on a miss
  npcc_datapath #(
    .CACHE_DEPTH  (CACHE_DEPTH),
    .PALETTE_SIZE (PALETTE_SIZE)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .red            (red),
    .green          (green),
    .blue           (blue),
    .palette_count  (palette_count),
    .color_index    (color_index),
    .cache_hit      (cache_hit),
    .cmd            (cmd),
    .status         (status)
  );

endmodule

// ===== rtl/core/npcc_ctrl.sv =====
// controller state machine of the nearest palette color cache
module npcc_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  npcc_pkg::status_t  status,
  output npcc_pkg::cmd_t     cmd
);

  localparam logic [2:0] ST_CLEAR  = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_LOOKUP = 3'd2;
  localparam logic [2:0] ST_CHECK  = 3'd3;
  localparam logic [2:0] ST_SEARCH = 3'd4;
  localparam logic [2:0] ST_FINISH = 3'd5;

  logic [2:0]            state;
  logic [2:0]            state_next;
  npcc_pkg::result_src_t src;
  npcc_pkg::result_src_t src_next;
  logic                  out_free;

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == ST_IDLE);

  always_comb begin
    cmd        = '0;
    cmd.src    = src;
    state_next = state;
    src_next   = src;
    unique case (state)
      ST_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (status.clear_done) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          if (status.dump_mode) begin
            src_next   = npcc_pkg::SRC_DUMP;
            state_next = ST_FINISH;
          end else begin
            state_next = ST_LOOKUP;
          end
        end
      end
      ST_LOOKUP: begin
        cmd.lookup = 1'b1;
        state_next = ST_CHECK;
      end
      ST_CHECK: begin
        if (status.tag_hit) begin
          src_next   = npcc_pkg::SRC_HIT;
          state_next = ST_FINISH;
        end else begin
          cmd.search_start = 1'b1;
          state_next       = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        cmd.search_step = 1'b1;
        if (status.search_done) begin
          cmd.cache_write = 1'b1;
          src_next        = npcc_pkg::SRC_SEARCH;
          state_next      = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          cmd.result_load = 1'b1;
          state_next      = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      src       <= npcc_pkg::SRC_DUMP;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      src   <= src_next;
      if (cmd.result_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/core/npcc_datapath.sv =====
// datapath of the nearest palette color cache: cache memory, hash and search
module npcc_datapath #(
  parameter int CACHE_DEPTH  = npcc_pkg::DEF_CACHE_DEPTH,
  parameter int PALETTE_SIZE = npcc_pkg::DEF_PALETTE_SIZE
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write_en,
  input  logic                            cfg_write_data,
  input  logic [npcc_pkg::COMP_W-1:0]     red,
  input  logic [npcc_pkg::COMP_W-1:0]     green,
  input  logic [npcc_pkg::COMP_W-1:0]     blue,
  input  logic [npcc_pkg::CNT_W-1:0]      palette_count,
  output logic [npcc_pkg::IDX_W-1:0]      color_index,
  output logic                            cache_hit,
  input  npcc_pkg::cmd_t                  cmd,
  output npcc_pkg::status_t               status
);

  localparam int AW        = $clog2(CACHE_DEPTH);
  localparam int SUM_W     = 12;
  localparam int REM_W     = 20;
  localparam int MOD_STEPS = 4;
  localparam int SQ_W      = 2 * npcc_pkg::COMP_W;
  localparam int WD_W      = 20;
  localparam logic [REM_W-1:0]            DEPTH_R   = REM_W'(CACHE_DEPTH);
  localparam logic [AW-1:0]               CLR_LAST  = AW'(CACHE_DEPTH - 1);
  localparam logic [npcc_pkg::CNT_W-1:0]  CNT_LIMIT = npcc_pkg::CNT_W'(PALETTE_SIZE);

  logic [npcc_pkg::ENTRY_W-1:0] mem [CACHE_DEPTH];
  logic [npcc_pkg::ENTRY_W-1:0] rd_data;
  logic [npcc_pkg::ENTRY_W-1:0] wr_data;
  logic [AW-1:0]                addr;
  logic [AW-1:0]                slot;
  logic [AW-1:0]                clr_addr;
  logic                         wr_en;

  logic [npcc_pkg::COMP_W-1:0]  red_q;
  logic [npcc_pkg::COMP_W-1:0]  green_q;
  logic [npcc_pkg::COMP_W-1:0]  blue_q;
  logic [npcc_pkg::CNT_W-1:0]   cnt_q;
  logic                         dump_mode;

  logic [SUM_W-1:0]             hash_sum;
  logic [REM_W-1:0]             hash_rem;

  logic [npcc_pkg::CNT_W-1:0]   srch_idx;
  logic [npcc_pkg::COLOR_W-1:0] pal;
  logic [npcc_pkg::COMP_W-1:0]  dr, dg, db;
  logic [SQ_W-1:0]              sq_r, sq_g, sq_b;
  logic [WD_W-1:0]              wdist;
  logic [WD_W-1:0]              dist_q;
  logic [npcc_pkg::IDX_W-1:0]   dist_idx;
  logic                         dist_valid;
  logic [npcc_pkg::DIST_W-1:0]  best_dist;
  logic [npcc_pkg::IDX_W-1:0]   best_idx;

  // slot index, reduced modulo the depth by conditional subtracts
  always_comb begin
    hash_sum = SUM_W'({red_q, 3'b000}) + SUM_W'({green_q, 2'b00})
             + SUM_W'(blue_q) + SUM_W'(cnt_q);
    hash_rem = REM_W'(hash_sum);
    for (int k = MOD_STEPS - 1; k >= 0; k--) begin
      if (hash_rem >= (DEPTH_R << k)) begin
        hash_rem = hash_rem - (DEPTH_R << k);
      end
    end
  end
  assign slot = hash_rem[AW-1:0];

  assign addr    = cmd.clear_step ? clr_addr : slot;
  assign wr_en   = cmd.clear_step || cmd.cache_write;
  assign wr_data = cmd.clear_step ? '0 : {1'b1, red_q, green_q, blue_q, cnt_q, best_idx};

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr] <= wr_data;
    end
    if (cmd.lookup) begin
      rd_data <= mem[addr];
    end
  end

  // weighted distance to the palette entry under test
  always_comb begin
    pal  = npcc_pkg::pal_color(srch_idx[npcc_pkg::IDX_W-1:0]);
    dr   = (red_q > pal[23:16]) ? red_q - pal[23:16] : pal[23:16] - red_q;
    dg   = (green_q > pal[15:8]) ? green_q - pal[15:8] : pal[15:8] - green_q;
    db   = (blue_q > pal[7:0]) ? blue_q - pal[7:0] : pal[7:0] - blue_q;
    sq_r = SQ_W'(dr) * SQ_W'(dr);
    sq_g = SQ_W'(dg) * SQ_W'(dg);
    sq_b = SQ_W'(db) * SQ_W'(db);
    wdist = (WD_W'(sq_r) << 1) + WD_W'(sq_r)
          + (WD_W'(sq_g) << 2)
          + (WD_W'(sq_b) << 1);
  end

  assign status.clear_done  = (clr_addr == CLR_LAST);
  assign status.dump_mode   = dump_mode;
  assign status.tag_hit     = rd_data[npcc_pkg::ENTRY_W-1]
                           && (rd_data[npcc_pkg::ENTRY_W-2:npcc_pkg::CNT_W+npcc_pkg::IDX_W]
                               == {red_q, green_q, blue_q})
                           && (rd_data[npcc_pkg::CNT_W+npcc_pkg::IDX_W-1:npcc_pkg::IDX_W]
                               == cnt_q);
  assign status.search_done = (srch_idx >= cnt_q) && !dist_valid;

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      dump_mode  <= 1'b0;
      clr_addr   <= '0;
      dist_valid <= 1'b0;
      srch_idx   <= '0;
    end else begin
      if (cfg_write_en) begin
        dump_mode <= cfg_write_data;
      end
      if (cmd.clear_step) begin
        clr_addr <= clr_addr + AW'(1);
      end
      if (cmd.search_start) begin
        srch_idx   <= '0;
        dist_valid <= 1'b0;
      end else if (cmd.search_step) begin
        if (srch_idx < cnt_q) begin
          srch_idx   <= npcc_pkg::CNT_W'(srch_idx + npcc_pkg::CNT_W'(1));
          dist_valid <= 1'b1;
        end else begin
          dist_valid <= 1'b0;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      red_q   <= red;
      green_q <= green;
      blue_q  <= blue;
      cnt_q   <= (palette_count > CNT_LIMIT) ? CNT_LIMIT : palette_count;
    end
    if (cmd.search_start) begin
      best_dist <= npcc_pkg::DIST_START;
      best_idx  <= '0;
    end else if (cmd.search_step) begin
      if (srch_idx < cnt_q) begin
        dist_q   <= wdist;
        dist_idx <= srch_idx[npcc_pkg::IDX_W-1:0];
      end
      // strict compare keeps the lower index on a tie
      if (dist_valid && (npcc_pkg::DIST_W'(dist_q) < best_dist)) begin
        best_dist <= npcc_pkg::DIST_W'(dist_q);
        best_idx  <= dist_idx;
      end
    end
    if (cmd.result_load) begin
      unique case (cmd.src)
        npcc_pkg::SRC_HIT: begin
          color_index <= rd_data[npcc_pkg::IDX_W-1:0];
          cache_hit   <= 1'b1;
        end
        npcc_pkg::SRC_SEARCH: begin
          color_index <= best_idx;
          cache_hit   <= 1'b0;
        end
        default: begin
          color_index <= '0;
          cache_hit   <= 1'b0;
        end
      endcase
    end
  end

endmodule

// ===== rtl/core/npcc_checker.sv =====
// port-level checker of the nearest palette color cache and its bind
`include "assert_macros.svh"

module npcc_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [npcc_pkg::IDX_W-1:0]  color_index,
  input logic                        cache_hit
);

  // a stalled result holds
  `ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(color_index) && $stable(cache_hit), "output item changed while stalled")

  // one item at a time: ready drops right after an accept
  `ASSERT_NEXT(a_one_in_flight, clk, rst, in_valid && in_ready, !in_ready, "input accepted while an item is in flight")

  // reset starts the clearing pass with nothing shown
  `ASSERT_NEXT_ALWAYS(a_reset_quiet, clk, rst, !in_ready && !out_valid, "ready or valid high after reset")

endmodule

bind nearest_palette_color_cache_unit npcc_checker u_npcc_checker (.*);

// ===== tb/sv/tb.sv =====
// testbench for nearest_palette_color_cache_unit: palette search and cache prediction, scoreboard
`timescale 1ns / 1ps

module tb;

  localparam int CACHE_LINES = npcc_pkg::DEF_CACHE_DEPTH;
  localparam int PAL_ENTRIES = npcc_pkg::DEF_PALETTE_SIZE;
  // quiet cycles let through before a register write or the end of the run
  localparam int HOLD_CYCLES = 24;
  // cycles with no handshake at all before the run is called hung
  localparam int STALL_LIMIT = 30000;

  // text-mode palette, entry 0 in the low bits
  localparam logic [15:0][npcc_pkg::COLOR_W-1:0] SWATCH = {
    24'hffffff, 24'h55ffff, 24'hff55ff, 24'h5555ff,
    24'hffff55, 24'h55ff55, 24'hff5555, 24'h555555,
    24'haaaaaa, 24'h008080, 24'h800080, 24'h000080,
    24'haa5500, 24'h008000, 24'h800000, 24'h000000
  };

  typedef struct packed {
    logic [npcc_pkg::COMP_W-1:0] r;
    logic [npcc_pkg::COMP_W-1:0] g;
    logic [npcc_pkg::COMP_W-1:0] b;
    logic [npcc_pkg::CNT_W-1:0]  cnt;
  } lookup_t;

  typedef struct packed {
    logic [npcc_pkg::IDX_W-1:0] idx;
    logic                       hit;
  } answer_t;

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        cfg_write_en = 1'b0;
  logic                        cfg_write_data = 1'b0;
  logic                        in_valid = 1'b0;
  logic                        in_ready;
  logic [npcc_pkg::COMP_W-1:0] red = '0;
  logic [npcc_pkg::COMP_W-1:0] green = '0;
  logic [npcc_pkg::COMP_W-1:0] blue = '0;
  logic [npcc_pkg::CNT_W-1:0]  palette_count = '0;
  logic                        out_valid;
  logic                        out_ready = 1'b0;
  logic [npcc_pkg::IDX_W-1:0]  color_index;
  logic                        cache_hit;

  nearest_palette_color_cache_unit DUT (
    .clk            (clk),
    .rst            (rst),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .red            (red),
    .green          (green),
    .blue           (blue),
    .palette_count  (palette_count),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .color_index    (color_index),
    .cache_hit      (cache_hit)
  );

  // 12 ns clock
  initial begin
    forever #6 clk = ~clk;
  end

  // lookups waiting to be driven, answers waiting to come back
  lookup_t lookup_q[$];
  answer_t answer_q[$];
  // recently issued colors, reused to land cache hits
  lookup_t recent[$];

  // shadow of the dump mode register and of the match cache
  bit                          dump_on = 1'b0;
  bit                          slot_live [CACHE_LINES];
  logic [npcc_pkg::COLOR_W-1:0] slot_rgb [CACHE_LINES];
  logic [npcc_pkg::CNT_W-1:0]  slot_cnt [CACHE_LINES];
  logic [npcc_pkg::IDX_W-1:0]  slot_idx [CACHE_LINES];

  // no random idling on either side while set
  bit no_gaps = 1'b0;
  int errors = 0;
  int quiet_cycles = 0;

  // expected answer for one accepted lookup; updates the shadow cache
  function automatic answer_t nearest_match(lookup_t q);
    answer_t                      a;
    int unsigned                  n;
    int unsigned                  slot;
    int unsigned                  best_d;
    int unsigned                  d;
    int                           dr;
    int                           dg;
    int                           db;
    logic [npcc_pkg::COLOR_W-1:0] rgb;
    logic [npcc_pkg::COLOR_W-1:0] pe;
    a = '0;
    // dump mode answers zero and leaves the cache alone
    if (dump_on) return a;
    // counts above the palette size saturate before hashing and tagging
    n = (q.cnt > PAL_ENTRIES) ? PAL_ENTRIES : q.cnt;
    rgb = {q.r, q.g, q.b};
    slot = ((int'(q.r) << 3) + (int'(q.g) << 2) + int'(q.b) + n) % CACHE_LINES;
    if (slot_live[slot] && slot_rgb[slot] == rgb && slot_cnt[slot] == n) begin
      a.idx = slot_idx[slot];
      a.hit = 1'b1;
      return a;
    end
    // weighted distance, strict less-than keeps the lower index on ties
    best_d = npcc_pkg::DIST_START;
    for (int i = 0; i < n; i++) begin
      pe = SWATCH[i];
      dr = int'(q.r) - int'(pe[23:16]);
      dg = int'(q.g) - int'(pe[15:8]);
      db = int'(q.b) - int'(pe[7:0]);
      d = 3 * dr * dr + 4 * dg * dg + 2 * db * db;
      if (d < best_d) begin
        best_d = d;
        a.idx = npcc_pkg::IDX_W'(i);
      end
    end
    // a miss overwrites whatever the line held
    slot_live[slot] = 1'b1;
    slot_rgb[slot] = rgb;
    slot_cnt[slot] = npcc_pkg::CNT_W'(n);
    slot_idx[slot] = a.idx;
    return a;
  endfunction

  function automatic logic [7:0] jitter(logic [7:0] c);
    int v;
    v = int'(c) + int'($urandom_range(0, 6)) - 3;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return 8'(v);
  endfunction

  task automatic queue_item(lookup_t q);
    lookup_q.push_back(q);
    recent.push_back(q);
    if (recent.size() > 64) void'(recent.pop_front());
  endtask

  task automatic queue_rgb(int r, int g, int b, int c);
    lookup_t q;
    q.r = 8'(r);
    q.g = 8'(g);
    q.b = 8'(b);
    q.cnt = 5'(c);
    queue_item(q);
  endtask

  // random lookups: repeats for hits, colors near entries, midpoints for ties, plain noise
  task automatic queue_random(int n);
    lookup_t                      q;
    int                           sel;
    logic [npcc_pkg::COLOR_W-1:0] p;
    logic [npcc_pkg::COLOR_W-1:0] p2;
    for (int k = 0; k < n; k++) begin
      sel = $urandom_range(0, 99);
      p = SWATCH[$urandom_range(0, 15)];
      p2 = SWATCH[$urandom_range(0, 15)];
      q.cnt = ($urandom_range(0, 99) < 80) ? 5'($urandom_range(0, 16))
                                           : 5'($urandom_range(17, 31));
      if (sel < 35 && recent.size() > 0) begin
        q = recent[$urandom_range(0, recent.size() - 1)];
        // a saturated count hits the same line as sixteen
        if (q.cnt >= 16 && $urandom_range(0, 1) == 1) q.cnt = 5'($urandom_range(16, 31));
      end else if (sel < 55) begin
        q.r = jitter(p[23:16]);
        q.g = jitter(p[15:8]);
        q.b = jitter(p[7:0]);
      end else if (sel < 65) begin
        q.r = 8'((9'(p[23:16]) + 9'(p2[23:16])) >> 1);
        q.g = 8'((9'(p[15:8]) + 9'(p2[15:8])) >> 1);
        q.b = 8'((9'(p[7:0]) + 9'(p2[7:0])) >> 1);
      end else begin
        q.r = 8'($urandom);
        q.g = 8'($urandom);
        q.b = 8'($urandom);
      end
      queue_item(q);
    end
  endtask

  // register writes only happen with nothing in flight
  task automatic set_dump(bit v);
    @(posedge clk);
    cfg_write_en <= 1'b1;
    cfg_write_data <= v;
    dump_on = v;
    @(posedge clk);
    cfg_write_en <= 1'b0;
  endtask

  // wait until every lookup is answered, then let the pipeline settle
  task automatic drain();
    while (lookup_q.size() != 0 || answer_q.size() != 0 || in_valid) @(posedge clk);
    repeat (HOLD_CYCLES) @(posedge clk);
  endtask

  task automatic set_gaps(bit off);
    @(posedge clk);
    no_gaps <= off;
  endtask

  // stimulus sequence
  initial begin
    for (int i = 0; i < CACHE_LINES; i++) begin
      slot_live[i] = 1'b0;
      slot_rgb[i] = '0;
      slot_cnt[i] = '0;
      slot_idx[i] = '0;
    end
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    // written during the clearing pass, block takes it
    set_dump(1'b0);

    // directed: extremes, count zero, saturation, ties, collisions
    queue_rgb(0, 0, 0, 16);
    queue_rgb(255, 255, 255, 16);
    queue_rgb(255, 255, 255, 0);
    queue_rgb(255, 255, 255, 1);
    queue_rgb(255, 255, 255, 31);
    queue_rgb(255, 255, 255, 17);
    queue_rgb(255, 255, 255, 16);
    queue_rgb(8'h40, 0, 0, 16);
    queue_rgb(8'haa, 8'h55, 0, 16);
    queue_rgb(8'h55, 8'h55, 8'hff, 16);
    queue_rgb(8'haa, 8'haa, 8'haa, 8);
    queue_rgb(8'haa, 8'haa, 8'haa, 7);
    // same line, different tags: evict and miss again
    queue_rgb(1, 0, 0, 0);
    queue_rgb(0, 2, 0, 0);
    queue_rgb(1, 0, 0, 0);
    queue_rgb(8'h80, 8'h80, 8'h80, 16);
    queue_rgb(8'h80, 8'h80, 8'h80, 16);
    queue_rgb(8'h80, 8'h80, 8'h80, 15);
    queue_rgb(255, 0, 255, 2);
    queue_rgb(8'h15, 8'haa, 8'h3c, 10);
    drain();

    // dump mode: zero answers, cache untouched
    set_dump(1'b1);
    queue_rgb(255, 255, 255, 16);
    queue_rgb(8'h20, 8'h20, 8'h20, 31);
    queue_rgb(0, 0, 0, 0);
    queue_random(120);
    drain();

    // back to searching: old lines still hit, dump items never cached
    set_dump(1'b0);
    queue_rgb(255, 255, 255, 16);
    queue_rgb(8'h20, 8'h20, 8'h20, 16);
    queue_random(500);
    drain();

    // long stretch with both sides always ready
    set_dump(1'b0);
    set_gaps(1'b1);
    queue_random(300);
    drain();
    set_gaps(1'b0);

    set_dump(1'b1);
    queue_random(80);
    drain();

    set_dump(1'b0);
    queue_random(350);
    drain();

    if (answer_q.size() != 0) errors++;
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // driver: one lookup at a time, held until taken, random gaps between
  lookup_t held;
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        answer_q.push_back(nearest_match(held));
      end
      if ((!in_valid || in_ready) && lookup_q.size() > 0
          && (no_gaps || $urandom_range(0, 99) >= 32)) begin
        held = lookup_q.pop_front();
        in_valid <= 1'b1;
        red <= held.r;
        green <= held.g;
        blue <= held.b;
        palette_count <= held.cnt;
      end else if (in_valid && in_ready) begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor: random backpressure, compare each answer with the oldest prediction
  answer_t want;
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= no_gaps || ($urandom_range(0, 99) >= 32);
      if (out_valid && out_ready) begin
        if (answer_q.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected item: color_index=%0d cache_hit=%0d", color_index, cache_hit);
        end else begin
          want = answer_q.pop_front();
          if (color_index !== want.idx || cache_hit !== want.hit) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: color_index exp %0d got %0d, cache_hit exp %0d got %0d",
                       want.idx, color_index, want.hit, cache_hit);
          end
        end
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || cfg_write_en) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

endmodule
